>>> hdl/hlc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hlc_pkg: shared types and constants of the hybrid logical clock
// Holds the stamp width, the default logical width, the operation codes, the
// offset reset value and the result record handed between the clock modules.
// ----------------------------------------------------------------------------
package hlc_pkg;

	localparam int STAMP_W = 64;
	localparam int LOGICAL_BITS_DEF = 18;

	localparam logic [STAMP_W-1:0] OFFSET_RESET = 64'd16000000000;

	localparam logic OP_LOCAL   = 1'b0;
	localparam logic OP_MESSAGE = 1'b1;

	typedef logic [STAMP_W-1:0] stamp_t;

	// Outcome of one clock update.
	typedef struct packed {
		stamp_t stamp;
		stamp_t lead;
		logic   sync_error;
		logic   clock_we;
	} hlc_upd_t;

endpackage
`default_nettype wire

>>> hdl/hlc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hlc_if: handshake channels of the hybrid logical clock
// Request, result and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface hlc_req_if;
	import hlc_pkg::*;
	logic   valid;
	logic   ready;
	logic   operation;
	stamp_t phys_time;
	stamp_t msg_stamp;
	modport source (output valid, output operation, output phys_time, output msg_stamp,
		input ready);
	modport sink (input valid, input operation, input phys_time, input msg_stamp,
		output ready);
endinterface

interface hlc_rsp_if;
	import hlc_pkg::*;
	logic   valid;
	logic   ready;
	stamp_t stamp;
	stamp_t lead;
	logic   sync_error;
	modport source (output valid, output stamp, output lead, output sync_error,
		input ready);
	modport sink (input valid, input stamp, input lead, input sync_error,
		output ready);
endinterface

interface hlc_cfg_if;
	import hlc_pkg::*;
	logic   valid;
	logic   ready;
	stamp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/hybrid_logical_clock.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hybrid_logical_clock: 64-bit hybrid logical clock
// Issues timestamps for local events and merges stamps of received messages.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries one beat per event: the operation (local or
//   message merge), the local physical time and, for a merge, the received
//   stamp. The result channel returns one beat per request with the new
//   stamp, the measured message lead and a sync error flag. The config
//   channel writes max_offset, which is stored rounded up to a multiple of
//   2^LOGICAL_BITS; the user must write it only while no request is in
//   flight, and the block itself does not enforce this. A request beat is
//   captured into an input register, the update is computed in a single
//   combinational pass against the clock register, and the result is
//   registered. The clock register updates on that same edge, so the next
//   request sees it at once. A beat passes the input and result registers;
//   throughput without receiver stalls is one beat per cycle, set by the single clock-register update loop.
//   When the receiver stalls, the result register holds its beat, the input
//   register takes one more request, and then request ready drops.
//   Reset clears the clock word to zero, empties both registers and loads
//   max_offset with its reset value (16e9 units).
// ----------------------------------------------------------------------------
module hybrid_logical_clock #(
	parameter int LOGICAL_BITS = hlc_pkg::LOGICAL_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	hlc_req_if.sink   request,
	hlc_rsp_if.source result,
	hlc_cfg_if.sink   cfg
);
	import hlc_pkg::*;

	localparam stamp_t LOGIC_MASK = STAMP_W'((65'd1 << LOGICAL_BITS) - 65'd1);
	localparam stamp_t PHYS_MASK  = ~LOGIC_MASK;

	// Input register.
	logic   vld_s1;
	logic   op_s1;
	stamp_t phys_s1;
	stamp_t msg_s1;

	// Result register.
	logic   vld_s2;
	stamp_t stamp_s2;
	stamp_t lead_s2;
	logic   err_s2;

	stamp_t   clock_word_q;
	stamp_t   max_offset_q;
	hlc_upd_t upd;
	logic     req_fire;
	logic     adv_s1;
	logic     cfg_fire;

	// The input register moves into the result register whenever the result
	// register is empty or its beat is being taken.
	assign adv_s1        = vld_s1 & (~vld_s2 | result.ready);
	assign request.ready = ~vld_s1 | adv_s1;
	assign req_fire      = request.valid & request.ready;
	assign cfg.ready     = 1'b1;
	assign cfg_fire      = cfg.valid & cfg.ready;

	hlc_update #(
		.LOGICAL_BITS(LOGICAL_BITS)
	) u_update (
		.operation  (op_s1),
		.phys_time  (phys_s1),
		.msg_stamp  (msg_s1),
		.clock_word (clock_word_q),
		.max_offset (max_offset_q),
		.upd        (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			clock_word_q <= '0;
			max_offset_q <= OFFSET_RESET;
		end else begin
			if (req_fire) begin
				vld_s1 <= 1'b1;
			end else if (adv_s1) begin
				vld_s1 <= 1'b0;
			end
			if (adv_s1) begin
				vld_s2 <= 1'b1;
			end else if (result.ready) begin
				vld_s2 <= 1'b0;
			end
			if (adv_s1 && upd.clock_we) begin
				clock_word_q <= upd.stamp;
			end
			if (cfg_fire) begin
				max_offset_q <= (cfg.data + LOGIC_MASK) & PHYS_MASK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_s1   <= request.operation;
			phys_s1 <= request.phys_time;
			msg_s1  <= request.msg_stamp;
		end
		if (adv_s1) begin
			stamp_s2 <= upd.stamp;
			lead_s2  <= upd.lead;
			err_s2   <= upd.sync_error;
		end
	end

	assign result.valid      = vld_s2;
	assign result.stamp      = stamp_s2;
	assign result.lead       = lead_s2;
	assign result.sync_error = err_s2;

	// A rejected message issues a zero stamp.
	a_err_zero_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && err_s2 |-> stamp_s2 == '0)
		else $error("sync error beat carries a nonzero stamp");

	// A rejected message really led by more than the allowed offset.
	a_err_lead: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && err_s2 |-> lead_s2 > max_offset_q)
		else $error("sync error flagged within the allowed offset");

	// While a good beat waits, the clock register holds the stamp it issued.
	a_clock_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !err_s2 |-> clock_word_q == stamp_s2)
		else $error("clock register differs from the pending stamp");

	// A written offset is always a whole number of physical ticks.
	a_offset_round: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_fire |=> (max_offset_q & LOGIC_MASK) == '0)
		else $error("written offset has logical bits set");

endmodule
`default_nettype wire

>>> hdl/hlc_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hlc_update: next-value logic of the hybrid logical clock
// Masks the physical time, measures the message lead and applies the local
// or four-case merge rule in one combinational pass.
// ----------------------------------------------------------------------------
module hlc_update #(
	parameter int LOGICAL_BITS = hlc_pkg::LOGICAL_BITS_DEF
) (
	input  wire logic             operation,
	input  wire hlc_pkg::stamp_t  phys_time,
	input  wire hlc_pkg::stamp_t  msg_stamp,
	input  wire hlc_pkg::stamp_t  clock_word,
	input  wire hlc_pkg::stamp_t  max_offset,
	output hlc_pkg::hlc_upd_t     upd
);
	import hlc_pkg::*;

	localparam stamp_t LOGIC_MASK = STAMP_W'((65'd1 << LOGICAL_BITS) - 65'd1);
	localparam stamp_t PHYS_MASK  = ~LOGIC_MASK;

	stamp_t pt;
	stamp_t ml;
	stamp_t cur_phys;
	stamp_t lead;
	stamp_t cur_inc;
	stamp_t msg_inc;
	stamp_t max_inc;

	assign pt       = phys_time & PHYS_MASK;
	assign ml       = msg_stamp & PHYS_MASK;
	assign cur_phys = clock_word & PHYS_MASK;
	assign lead     = (ml > pt) ? (ml - pt) : '0;
	assign cur_inc  = clock_word + STAMP_W'(1);
	assign msg_inc  = msg_stamp + STAMP_W'(1);
	assign max_inc  = (clock_word < msg_stamp) ? msg_inc : cur_inc;

	always_comb begin
		upd.stamp      = cur_inc;
		upd.lead       = '0;
		upd.sync_error = 1'b0;
		upd.clock_we   = 1'b1;
		if (operation == OP_LOCAL) begin
			upd.stamp = (cur_phys < pt) ? pt : cur_inc;
		end else begin
			upd.lead = lead;
			if (lead > max_offset) begin
				// The message runs too far ahead: report it, keep the clock.
				upd.stamp      = '0;
				upd.sync_error = 1'b1;
				upd.clock_we   = 1'b0;
			end else if (cur_phys < ml) begin
				upd.stamp = (ml < pt) ? pt : msg_inc;
			end else if (cur_phys < pt) begin
				upd.stamp = pt;
			end else if (pt <= ml) begin
				upd.stamp = max_inc;
			end else begin
				upd.stamp = cur_inc;
			end
		end
	end

endmodule
`default_nettype wire

>>> test/hybrid_logical_clock_tb.sv
// ----------------------------------------------------------------------------
// hybrid_logical_clock_tb: self-checking bench for the hybrid logical clock
// Drives local and merge requests through the request channel, predicts each
// result beat in the bench itself and checks every returned beat in order.
// The offset register is swept through several settings, extremes included.
// ----------------------------------------------------------------------------
module hybrid_logical_clock_tb;
	import hlc_pkg::*;

	localparam int    LB         = LOGICAL_BITS_DEF;
	localparam stamp_t LOGIC_MASK = (64'd1 << LB) - 64'd1;
	localparam stamp_t PHYS_MASK  = ~LOGIC_MASK;
	localparam int    CYCLE_LIMIT = 300000;
	localparam int    STALL_CYCLES = 60;
	localparam int    RANDOM_FIRST = 150;
	localparam int    RANDOM_PHASE = 80;

	// One result beat as the bench expects it.
	typedef struct packed {
		stamp_t stamp;
		stamp_t lead;
		logic   sync_error;
	} clock_result_t;

	// One row of the directed table. When typed is set, the expected result
	// is taken from the row; otherwise it comes from the predictor.
	typedef struct packed {
		logic   op;
		stamp_t phys;
		stamp_t msg;
		logic   typed;
		stamp_t stamp;
		stamp_t lead;
		logic   sync_error;
	} directed_row_t;

	localparam int DIRECTED_N = 18;

	// The rows run straight after reset, with the clock at zero and the offset
	// limit at its reset value of 16e9 units, which is not a multiple of 2^18.
	localparam directed_row_t DIRECTED [DIRECTED_N] = '{
		// First local request after reset simply counts up from zero.
		'{OP_LOCAL,   64'd0,                  64'd0,                  1'b1,
			64'd1, 64'd0, 1'b0},
		// The low logical bits of the physical time are dropped, so this is
		// still not ahead of the clock and the counter steps again.
		'{OP_LOCAL,   64'h3FFFF,              '1,                     1'b1,
			64'd2, 64'd0, 1'b0},
		// Physical time one unit ahead of the clock is taken as it is.
		'{OP_LOCAL,   64'h40000,              64'd0,                  1'b1,
			64'h40000, 64'd0, 1'b0},
		// Message equal to the local time and the clock: maximum plus one.
		'{OP_MESSAGE, 64'h40000,              64'h40000,              1'b0,
			64'd0, 64'd0, 1'b0},
		// Smallest whole-unit lead above the reset limit is a sync error.
		'{OP_MESSAGE, 64'd0,                  64'd16000221184,        1'b1,
			64'd0, 64'd16000221184, 1'b1},
		// Lead just below the reset limit is accepted; message ahead of clock.
		'{OP_MESSAGE, 64'd0,                  64'd15999959045,        1'b0,
			64'd0, 64'd0, 1'b0},
		// Message ahead of the clock but behind local time: local time wins.
		'{OP_MESSAGE, 64'h0000_0010_0000_0000, 64'h0000_0008_0000_0123, 1'b0,
			64'd0, 64'd0, 1'b0},
		// Message behind the clock, local time ahead of it.
		'{OP_MESSAGE, 64'h0000_0020_0000_0000, 64'h1234,              1'b0,
			64'd0, 64'd0, 1'b0},
		// Same physical part everywhere, message larger than the clock.
		'{OP_MESSAGE, 64'h0000_0020_0000_0000, 64'h0000_0020_0003_FFFF, 1'b0,
			64'd0, 64'd0, 1'b0},
		// Same physical part in message and local time, clock larger.
		'{OP_MESSAGE, 64'h0000_0020_0000_0000, 64'h0000_0020_0000_0000, 1'b0,
			64'd0, 64'd0, 1'b0},
		// Clock ahead of both, local time ahead of the message.
		'{OP_MESSAGE, 64'h0000_0020_0000_0000, 64'd0,                  1'b0,
			64'd0, 64'd0, 1'b0},
		// Largest possible lead: sync error, clock left alone.
		'{OP_MESSAGE, 64'd0,                  '1,                     1'b1,
			64'd0, 64'hFFFF_FFFF_FFFC_0000, 1'b1},
		// Largest physical time jumps the clock to the top.
		'{OP_LOCAL,   '1,                     64'd0,                  1'b1,
			64'hFFFF_FFFF_FFFC_0000, 64'd0, 1'b0},
		'{OP_LOCAL,   64'd0,                  64'd0,                  1'b1,
			64'hFFFF_FFFF_FFFC_0001, 64'd0, 1'b0},
		// All-ones message: maximum plus one wraps to zero.
		'{OP_MESSAGE, '1,                     '1,                     1'b0,
			64'd0, 64'd0, 1'b0},
		'{OP_LOCAL,   64'd0,                  64'd0,                  1'b0,
			64'd0, 64'd0, 1'b0},
		// Message plus one lands the clock on all ones ...
		'{OP_MESSAGE, '1,                     64'hFFFF_FFFF_FFFF_FFFE, 1'b0,
			64'd0, 64'd0, 1'b0},
		// ... and the next local count wraps to zero.
		'{OP_LOCAL,   64'd0,                  64'd0,                  1'b0,
			64'd0, 64'd0, 1'b0}
	};

	logic clk;
	logic arst_n;

	hlc_req_if req_ch ();
	hlc_rsp_if rsp_ch ();
	hlc_cfg_if cfg_ch ();

	hybrid_logical_clock uut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(req_ch),
		.result (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Bench copy of the block state and its offset register.
	stamp_t hlc_word;
	stamp_t offset_model;

	clock_result_t pending_stamps [$];
	clock_result_t head;

	int  fail_count;
	int  cycle_count;
	int  local_count;
	int  merge_count;
	int  sync_error_count;
	int  offset_writes;
	int  random_index;
	bit  steady;
	bit  stall_request;
	int  stall_left;

	initial begin
		clk = 1'b0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Runaway guard: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL hybrid_logical_clock");
			$finish;
		end
	end

	// Predicts one request against the bench copy of the clock. A local
	// request takes the masked physical time when it is ahead of the clock's
	// physical part and otherwise counts up. A merge first measures the lead
	// of the message over local time; past the offset limit it reports a sync
	// error and leaves the clock as it was. Otherwise the four-way merge picks
	// local time, message plus one, clock plus one, or the larger of clock and message plus one.
	function automatic clock_result_t advance_clock(logic op, stamp_t phys, stamp_t msg);
		stamp_t pt       = phys & PHYS_MASK;
		stamp_t ml       = msg & PHYS_MASK;
		stamp_t cur_phys = hlc_word & PHYS_MASK;
		stamp_t next;
		clock_result_t res;
		res.lead       = '0;
		res.sync_error = 1'b0;
		if (op == OP_LOCAL) begin
			next = (cur_phys < pt) ? pt : hlc_word + 64'd1;
		end else begin
			res.lead = (ml > pt) ? ml - pt : '0;
			if (res.lead > offset_model) begin
				res.stamp      = '0;
				res.sync_error = 1'b1;
				return res;
			end
			if (cur_phys < ml)
				next = (ml < pt) ? pt : msg + 64'd1;
			else if (cur_phys < pt)
				next = pt;
			else if (pt <= ml)
				next = ((hlc_word < msg) ? msg : hlc_word) + 64'd1;
			else
				next = hlc_word + 64'd1;
		end
		hlc_word  = next;
		res.stamp = next;
		return res;
	endfunction

	// Sender: optional idle cycles, then one request beat held until taken.
	// The expectation is queued on the edge where the beat is accepted.
	task automatic drive_request(input logic op, input stamp_t phys, input stamp_t msg,
		input logic typed, input clock_result_t typed_res);
		clock_result_t predicted;
		while (!steady && $urandom_range(0, 99) < 31) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.phys_time <= phys;
		req_ch.msg_stamp <= msg;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predicted = advance_clock(op, phys, msg);
		pending_stamps.push_back(typed ? typed_res : predicted);
		if (op == OP_LOCAL)
			local_count++;
		else
			merge_count++;
		if (predicted.sync_error)
			sync_error_count++;
	endtask

	// Stops offering requests and waits until every expected beat is back.
	task automatic drain_expected();
		req_ch.valid <= 1'b0;
		while (pending_stamps.size() != 0)
			@(posedge clk);
	endtask

	// The block is idle here; the bench copy stores the rounded-up value.
	task automatic write_offset(input stamp_t value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		offset_model = (value + LOGIC_MASK) & PHYS_MASK;
		offset_writes++;
	endtask

	function automatic stamp_t rand64();
		return {$urandom, $urandom};
	endfunction

	// A value within a few physical units of base, either side, with random
	// logical bits, so that ties and near misses in the merge come up often.
	function automatic stamp_t near_value(stamp_t base);
		stamp_t delta;
		delta = (stamp_t'($urandom_range(0, 7)) << LB) | (stamp_t'($urandom) & LOGIC_MASK);
		return $urandom_range(0, 1) ? base + delta : base - delta;
	endfunction

	// Random requests. Most are built around the current clock so that the
	// merge cases and the offset boundary are hit often; a share is fully
	// random to toggle every bit of both fields. The pressure events are tied
	// to positions in the overall random sequence.
	task automatic random_burst(input int count);
		int     kind;
		logic   op;
		stamp_t anchor;
		stamp_t phys;
		stamp_t msg;
		stamp_t step;
		for (int i = 0; i < count; i++) begin
			random_index++;
			steady = (random_index >= 200 && random_index < 330);
			if (random_index == 400)
				stall_request = 1'b1;
			if (random_index == 500)
				drain_expected();
			kind   = $urandom_range(0, 99);
			op     = $urandom_range(0, 1) ? OP_MESSAGE : OP_LOCAL;
			anchor = hlc_word;
			if (kind < 12) begin
				phys = rand64();
				msg  = rand64();
			end else begin
				phys = near_value(anchor);
				case ($urandom_range(0, 3))
					0: msg = near_value(anchor);
					1: msg = near_value(phys);
					2: begin
						// Lead just below, at or just above the offset limit.
						step = stamp_t'($urandom_range(0, 2)) << LB;
						msg  = (phys & PHYS_MASK) + offset_model + step - (64'd1 << LB)
							+ (stamp_t'($urandom) & LOGIC_MASK);
					end
					default: msg = anchor + stamp_t'($urandom_range(0, 2));
				endcase
			end
			drive_request(op, phys, msg, 1'b0, '0);
		end
	endtask

	// Receiver: random stalls, a quiet stretch with ready held high, and one
	// long hold-off so the block backs up into its request channel.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else if (stall_request) begin
				stall_request = 1'b0;
				stall_left    = STALL_CYCLES - 1;
				rsp_ch.ready <= 1'b0;
			end else if (steady) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= 31);
			end
		end
	end

	// Result checker: every accepted beat is matched against the oldest
	// expectation, field by field. Only the first ten failures are printed.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_stamps.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result beat: stamp %h lead %h sync_error %b",
						rsp_ch.stamp, rsp_ch.lead, rsp_ch.sync_error);
			end else begin
				head = pending_stamps.pop_front();
				if (rsp_ch.stamp !== head.stamp || rsp_ch.lead !== head.lead
					|| rsp_ch.sync_error !== head.sync_error) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"result mismatch: expected stamp %h lead %h err %b,",
							" got stamp %h lead %h err %b"},
							head.stamp, head.lead, head.sync_error,
							rsp_ch.stamp, rsp_ch.lead, rsp_ch.sync_error);
				end
			end
		end
	end

	initial begin
		stamp_t offsets [7];
		clock_result_t typed_res;

		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.operation = OP_LOCAL;
		req_ch.phys_time = '0;
		req_ch.msg_stamp = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.data      = '0;
		hlc_word         = '0;
		offset_model     = OFFSET_RESET;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table against the reset offset limit.
		for (int r = 0; r < DIRECTED_N; r++) begin
			typed_res.stamp      = DIRECTED[r].stamp;
			typed_res.lead       = DIRECTED[r].lead;
			typed_res.sync_error = DIRECTED[r].sync_error;
			drive_request(DIRECTED[r].op, DIRECTED[r].phys, DIRECTED[r].msg,
				DIRECTED[r].typed, typed_res);
		end
		random_burst(RANDOM_FIRST);

		// Offset settings: zero, all ones (rounds up and wraps to zero), the
		// largest multiple of 2^18, a value that rounds up to one unit, the
		// reset value written back (now rounded), and two random values.
		offsets[0] = '0;
		offsets[1] = '1;
		offsets[2] = 64'hFFFF_FFFF_FFFC_0000;
		offsets[3] = 64'd1;
		offsets[4] = OFFSET_RESET;
		offsets[5] = rand64();
		offsets[6] = {24'd0, $urandom, 8'd0};
		foreach (offsets[k]) begin
			drain_expected();
			write_offset(offsets[k]);
			random_burst(RANDOM_PHASE);
		end

		drain_expected();
		repeat (8) @(posedge clk);

		$display("Covered %0d local and %0d merge requests, %0d of them sync errors,",
			local_count, merge_count, sync_error_count);
		$display("across %0d offset register writes plus the reset setting.", offset_writes);
		if (fail_count == 0) begin
			$display("PASS hybrid_logical_clock");
		end else begin
			$display("FAIL hybrid_logical_clock");
		end
		$finish;
	end

endmodule
